@@ hdl/mfdfs_pkg.sv @@
// Package for the max-flow block: command and status codes, default sizes.
// No dependencies; used by max_flow_augmenting_dfs.
`timescale 1ns / 1ps
package mfdfs_pkg;
  localparam int NODES_DEF    = 16;
  localparam int EDGES_DEF    = 64;
  localparam int CAP_BITS_DEF = 16;

  // fixed field widths
  localparam int NODE_W = 4;
  localparam int NODE_IDS = 16;
  localparam int FLOW_W = 22;
  localparam logic [FLOW_W-1:0] FLOW_MAX = 22'h3FFFFF;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_SAME    = 2'd2;
endpackage

@@ hdl/max_flow_augmenting_dfs.sv @@
// Top level: edge store, residual store and an iterative DFS max-flow sequencer.
// Depends on mfdfs_pkg and mfdfs_ram.
//
//  channel  | signals                                             | handshake
//  ---------+-----------------------------------------------------+-----------------------
//  command  | command from_node to_node capacity source_node sink_node | start && !busy
//  result   | max_flow status                                     | done, one cycle
//
// Add and clear never raise busy. A run with source equal to sink, or with a node
// out of range, answers the next cycle. Otherwise a run copies each stored edge
// into its two residual entries, tests residual entries in the search and
// rewrites both entries of each augmenting path edge, all through the one
// residual RAM port pair. Reset clears the control state; the RAMs need no
// clearing. The result receiver cannot stall: done is high for one cycle.
`timescale 1ns / 1ps
module max_flow_augmenting_dfs #(
  parameter int NODES    = mfdfs_pkg::NODES_DEF,
  parameter int EDGES    = mfdfs_pkg::EDGES_DEF,
  parameter int CAP_BITS = mfdfs_pkg::CAP_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [3:0]  from_node,
  input  logic [3:0]  to_node,
  input  logic [15:0] capacity,
  input  logic [3:0]  source_node,
  input  logic [3:0]  sink_node,
  output logic        done,
  output logic [21:0] max_flow,
  output logic [1:0]  status
);
  localparam int NW    = mfdfs_pkg::NODE_W;
  localparam int EAW   = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int RAW   = $clog2(2 * EDGES);
  localparam int EIW   = RAW + 1;
  localparam int CNT_W = $clog2(EDGES + 1);
  localparam int LIM_W = CAP_BITS + 1;
  localparam int EW    = 2 * NW + CAP_BITS;
  localparam int SD    = mfdfs_pkg::NODE_IDS;
  localparam int SDW   = $clog2(SD);

  typedef enum logic [3:0] {
    S_IDLE, S_COPY_RD, S_COPY_W0, S_COPY_W1, S_RND, S_SCAN_RD, S_SCAN_CHK,
    S_AUG_RD, S_AUG_W0, S_AUG_W1
  } state_t;

  state_t state;
  logic [CNT_W-1:0] edge_count;
  logic dropped;
  logic [CNT_W-1:0] copy_k;
  logic [NW-1:0] src, snk;
  logic [SD-1:0] visited;
  logic [NW-1:0] cur_u;
  logic [EIW-1:0] cur_e;
  logic [LIM_W-1:0] cur_lim;
  logic [SDW-1:0] depth;
  logic [NW-1:0] stk_u [SD];
  logic [EIW-1:0] stk_e [SD];
  logic [LIM_W-1:0] stk_lim [SD];
  logic [CAP_BITS-1:0] aug_d;
  logic [mfdfs_pkg::FLOW_W-1:0] total;

  // edge store RAM
  logic e_we;
  logic [EAW-1:0] e_waddr, e_raddr;
  logic [EW-1:0] e_wdata, e_rdata;
  mfdfs_ram #(.WIDTH(EW), .DEPTH(EDGES)) u_edges (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  // residual store RAM
  logic r_we;
  logic [RAW-1:0] r_waddr, r_raddr;
  logic [CAP_BITS-1:0] r_wdata, r_rdata;
  mfdfs_ram #(.WIDTH(CAP_BITS), .DEPTH(2 * EDGES)) u_resid (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  logic accept;
  logic [EIW-1:0] scan_end;
  logic [NW-1:0] ent_tail, ent_head, e_tail, e_head;
  logic [CAP_BITS-1:0] e_cap;
  logic [LIM_W-1:0] rc_ext, new_lim;
  logic take;
  logic [31:0] sum;
  logic run_quick;
  logic done_next;

  assign accept   = start && !busy;
  assign scan_end = EIW'({edge_count, 1'b0});
  assign e_tail   = e_rdata[EW-1 -: NW];
  assign e_head   = e_rdata[CAP_BITS +: NW];
  assign e_cap    = e_rdata[CAP_BITS-1:0];

  // run answered at once: same node or a node out of range
  assign run_quick = (source_node == sink_node) ||
                     (7'(source_node) >= 7'(NODES)) || (7'(sink_node) >= 7'(NODES));

  // result strobe: quick run, or search finished with nothing left to backtrack
  assign done_next = ((state == S_IDLE) && accept &&
                      (command == mfdfs_pkg::CMD_RUN) && run_quick) ||
                     ((state == S_SCAN_RD) && (cur_e == scan_end) && (depth == '0));

  // residual entry decode: odd entries run head to tail
  always_comb begin
    ent_tail = cur_e[0] ? e_head : e_tail;
    ent_head = cur_e[0] ? e_tail : e_head;
    rc_ext   = LIM_W'(r_rdata);
    new_lim  = (rc_ext < cur_lim) ? rc_ext : cur_lim;
    take     = (ent_tail == cur_u) && (7'(ent_head) < 7'(NODES)) &&
               !visited[ent_head] && (r_rdata != '0);
    sum      = 32'(total) + 32'(aug_d);
  end

  // RAM address and write muxing
  always_comb begin
    e_we    = 1'b0;
    e_waddr = EAW'(edge_count);
    e_wdata = {from_node, to_node, CAP_BITS'(capacity)};
    e_raddr = EAW'(cur_e >> 1);
    r_we    = 1'b0;
    r_waddr = cur_e[RAW-1:0];
    r_wdata = '0;
    r_raddr = cur_e[RAW-1:0];
    unique case (state)
      S_IDLE: begin
        e_we = accept && (command == mfdfs_pkg::CMD_ADD) &&
               (edge_count != CNT_W'(EDGES));
      end
      S_COPY_RD: begin
        e_raddr = EAW'(copy_k);
      end
      S_COPY_W0: begin
        r_we    = 1'b1;
        r_waddr = RAW'({copy_k, 1'b0});
        r_wdata = e_cap;
      end
      S_COPY_W1: begin
        r_we    = 1'b1;
        r_waddr = RAW'({copy_k, 1'b1});
      end
      S_AUG_W0: begin
        r_we    = 1'b1;
        r_wdata = r_rdata - aug_d;
        r_raddr = {cur_e[RAW-1:1], ~cur_e[0]};
      end
      S_AUG_W1: begin
        r_we    = 1'b1;
        r_waddr = {cur_e[RAW-1:1], ~cur_e[0]};
        r_wdata = r_rdata + aug_d;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      busy       <= 1'b0;
      done       <= 1'b0;
      edge_count <= '0;
      dropped    <= 1'b0;
      visited    <= '0;
      depth      <= '0;
      total      <= '0;
    end else begin
      done <= done_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority case (command)
              mfdfs_pkg::CMD_ADD: begin
                if (edge_count == CNT_W'(EDGES)) begin
                  dropped <= 1'b1;
                end else begin
                  edge_count <= edge_count + 1'b1;
                end
              end
              mfdfs_pkg::CMD_CLEAR: begin
                edge_count <= '0;
                dropped    <= 1'b0;
              end
              mfdfs_pkg::CMD_RUN: begin
                total <= '0;
                src   <= source_node;
                snk   <= sink_node;
                if (source_node == sink_node) begin
                  max_flow <= '0;
                  status   <= mfdfs_pkg::ST_SAME;
                end else if (run_quick) begin
                  max_flow <= '0;
                  status   <= dropped ? mfdfs_pkg::ST_DROPPED : mfdfs_pkg::ST_OK;
                end else begin
                  busy   <= 1'b1;
                  copy_k <= '0;
                  state  <= S_COPY_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        // residual build: forward entry gets the capacity, reverse gets zero
        S_COPY_RD: begin
          state <= (copy_k == edge_count) ? S_RND : S_COPY_W0;
        end
        S_COPY_W0: begin
          state <= S_COPY_W1;
        end
        S_COPY_W1: begin
          copy_k <= copy_k + 1'b1;
          state  <= S_COPY_RD;
        end
        // start of a search round: only the source is marked
        S_RND: begin
          visited <= SD'(1) << src;
          cur_u   <= src;
          cur_e   <= '0;
          cur_lim <= '1;
          depth   <= '0;
          state   <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          if (cur_e == scan_end) begin
            if (depth == '0) begin
              busy     <= 1'b0;
              max_flow <= total;
              status   <= dropped ? mfdfs_pkg::ST_DROPPED : mfdfs_pkg::ST_OK;
              state    <= S_IDLE;
            end else begin
              // backtrack: parent moves to its next entry
              cur_u   <= stk_u[depth - 1'b1];
              cur_e   <= stk_e[depth - 1'b1] + 1'b1;
              cur_lim <= stk_lim[depth - 1'b1];
              depth   <= depth - 1'b1;
            end
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (take) begin
            visited[ent_head] <= 1'b1;
            if (ent_head == snk) begin
              aug_d <= CAP_BITS'(new_lim);
              state <= S_AUG_RD;
            end else begin
              stk_u[depth]   <= cur_u;
              stk_e[depth]   <= cur_e;
              stk_lim[depth] <= cur_lim;
              depth          <= depth + 1'b1;
              cur_u          <= ent_head;
              cur_e          <= '0;
              cur_lim        <= new_lim;
              state          <= S_SCAN_RD;
            end
          end else begin
            cur_e <= cur_e + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        // augment along the path, walking the stack down
        S_AUG_RD: begin
          state <= S_AUG_W0;
        end
        S_AUG_W0: begin
          state <= S_AUG_W1;
        end
        S_AUG_W1: begin
          if (depth == '0) begin
            total <= (sum > 32'(mfdfs_pkg::FLOW_MAX)) ? mfdfs_pkg::FLOW_MAX :
                     mfdfs_pkg::FLOW_W'(sum);
            state <= S_RND;
          end else begin
            cur_e <= stk_e[depth - 1'b1];
            depth <= depth - 1'b1;
            state <= S_AUG_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (command == mfdfs_pkg::CMD_RUN) && (source_node != sink_node) &&
     (7'(source_node) < 7'(NODES)) && (7'(sink_node) < 7'(NODES))) |=> busy)
    else $error("run not started");
  a_depth: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CHK) |-> (depth != '1))
    else $error("search stack overflow");
  a_cur_visited: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CHK) |-> visited[cur_u])
    else $error("current node not marked visited");
endmodule

@@ hdl/mfdfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mfdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
